[design/lpmr_pkg.sv]
// Shared types, constants and helpers for the length-prefixed message ring.
// No dependencies; used by lpmr_ctrl and length_prefixed_message_ring.
`default_nettype none

package lpmr_pkg;

    localparam int RING_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 8;

    localparam int DATA_W   = 8;
    localparam int LEN_W    = 12;
    localparam int CNT_W    = 12;
    localparam int RSV_W    = 8;
    localparam int LEN_HI_W = LEN_W - DATA_W;

    localparam logic [RSV_W-1:0] RSV_RESET = RSV_W'(8);
    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(4095);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DROP  = 2'd1,
        ST_ZERO  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_PUSH_HDR,
        S_PUSH_BODY,
        S_POP_HDR,
        S_POP_RD,
        S_POP_WAIT,
        S_RESULT
    } state_t;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] out_byte;
        logic              out_last;
        logic [CNT_W-1:0]  queued;
    } result_t;

    // Little-endian header byte; only the two low bytes can be nonzero.
    function automatic logic [DATA_W-1:0] hdr_byte(input logic [LEN_W-1:0] len,
                                                   input int unsigned idx);
        logic [DATA_W-1:0] b;
        b = '0;
        if (idx == 0)
            b = len[DATA_W-1:0];
        else if (idx == 1)
            b = {{(DATA_W-LEN_HI_W){1'b0}}, len[LEN_W-1:DATA_W]};
        return b;
    endfunction

endpackage

`default_nettype wire

[design/length_prefixed_message_ring.sv]
// Top level of the length-prefixed message ring: ports, config register, output register.
// Depends on lpmr_pkg and lpmr_ctrl (which holds lpmr_ram).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_stall  | mode, data_byte, message_length
//  out     | output    | out_valid / out_stall| status, out_byte, out_last, queued_messages
//  cfg     | input     | cfg_valid / cfg_ready| cfg_data (reserve_bytes)
//
// One transaction at a time runs through the sequencer; the single ring RAM port sets the pace.
// Stored push byte: DECIDE, PUSH_BODY, RESULT; a first byte adds HEADER_BYTES writes in PUSH_HDR.
// Pop byte: DECIDE, POP_RD, POP_WAIT, RESULT; a pop that opens a message adds HEADER_BYTES header reads.
// Dropped, zero-length and empty transactions go from DECIDE straight to RESULT.
// Reset clears pointers, counts and the reserve (to 8); ring RAM contents are not cleared.
// A result waits in the output register under out_stall while the next input is taken.
`default_nettype none

module length_prefixed_message_ring #(
    parameter int RING_BYTES   = lpmr_pkg::RING_BYTES_DEF,
    parameter int HEADER_BYTES = lpmr_pkg::HEADER_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        mode,
    input  wire logic [lpmr_pkg::DATA_W-1:0] data_byte,
    input  wire logic [lpmr_pkg::LEN_W-1:0]  message_length,

    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [1:0]                       status,
    output logic [lpmr_pkg::DATA_W-1:0]      out_byte,
    output logic                             out_last,
    output logic [lpmr_pkg::CNT_W-1:0]       queued_messages,

    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [lpmr_pkg::RSV_W-1:0]  cfg_data
);

    logic [lpmr_pkg::RSV_W-1:0] reserve_reg;
    logic                       out_valid_reg;
    lpmr_pkg::result_t          out_res_reg;

    logic              busy;
    logic              start;
    logic              res_valid;
    logic              res_ready;
    lpmr_pkg::result_t res;

    // sequencer only takes a transaction when idle
    assign in_stall  = busy;
    assign start     = in_valid && !busy;
    assign cfg_ready = 1'b1;

    // output register frees when empty or being drained this cycle
    assign res_ready = !out_valid_reg || !out_stall;

    lpmr_ctrl #(
        .RING_BYTES   (RING_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item_mode (mode),
        .item_data (data_byte),
        .item_len  (message_length),
        .reserve   (reserve_reg),
        .busy      (busy),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserve_reg   <= lpmr_pkg::RSV_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                reserve_reg <= cfg_data;
            if (res_valid && res_ready)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, held while stalled
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_res_reg <= res;
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_res_reg.status;
    assign out_byte        = out_res_reg.out_byte;
    assign out_last        = out_res_reg.out_last;
    assign queued_messages = out_res_reg.queued;

endmodule

`default_nettype wire

[design/lpmr_ram.sv]
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module lpmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[design/lpmr_ctrl.sv]
// Sequencer and pointer state for the message ring; owns the ring RAM.
// Depends on lpmr_pkg and lpmr_ram.
`default_nettype none

module lpmr_ctrl #(
    parameter int RING_BYTES   = lpmr_pkg::RING_BYTES_DEF,
    parameter int HEADER_BYTES = lpmr_pkg::HEADER_BYTES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         item_mode,
    input  wire logic [lpmr_pkg::DATA_W-1:0]  item_data,
    input  wire logic [lpmr_pkg::LEN_W-1:0]   item_len,
    input  wire logic [lpmr_pkg::RSV_W-1:0]   reserve,
    output logic                              busy,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output lpmr_pkg::result_t                 res
);

    localparam int PW = $clog2(RING_BYTES);
    localparam int HW = $clog2(HEADER_BYTES);
    localparam int SW = ((PW + 1) > (lpmr_pkg::LEN_W + 1)) ? (PW + 1) : (lpmr_pkg::LEN_W + 1);
    localparam logic [PW-1:0] RING_LAST = PW'(RING_BYTES - 1);
    localparam logic [HW-1:0] HDR_LAST  = HW'(HEADER_BYTES - 1);

    lpmr_pkg::state_t state_reg, state_next;

    logic                        mode_reg, mode_next;
    logic [lpmr_pkg::DATA_W-1:0] data_reg, data_next;
    logic [lpmr_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [PW-1:0]               rp_reg, rp_next;
    logic [PW-1:0]               cwp_reg, cwp_next;
    logic [PW-1:0]               pwp_reg, pwp_next;
    logic [lpmr_pkg::CNT_W-1:0]  total_reg, total_next;
    logic [lpmr_pkg::LEN_W-1:0]  push_left_reg, push_left_next;
    logic                        drop_reg, drop_next;
    logic [lpmr_pkg::LEN_W-1:0]  pop_left_reg, pop_left_next;
    logic [HW-1:0]               hcnt_reg, hcnt_next;
    logic                        opened_reg, opened_next;
    lpmr_pkg::status_t           rstat_reg, rstat_next;
    logic [lpmr_pkg::DATA_W-1:0] rbyte_reg, rbyte_next;
    logic                        rlast_reg, rlast_next;

    logic                          cap_valid_reg;
    logic [HW-1:0]                 cap_idx_reg;
    logic [lpmr_pkg::DATA_W-1:0]   len_lo_reg;
    logic [lpmr_pkg::LEN_HI_W-1:0] len_hi_reg;

    logic                        ram_we;
    logic [PW-1:0]               ram_addr;
    logic [lpmr_pkg::DATA_W-1:0] ram_wdata;
    logic [lpmr_pkg::DATA_W-1:0] ram_rdata;

    logic [PW:0]                 used;
    logic [PW:0]                 free_bytes;
    logic [SW-1:0]               rsv_eff;
    logic [SW-1:0]               need;
    logic                        no_room;
    logic [lpmr_pkg::LEN_W-1:0]  plen;
    logic [lpmr_pkg::LEN_W-1:0]  pop_left_dec;

    function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
        logic [PW-1:0] n;
        if (p == RING_LAST)
            n = '0;
        else
            n = p + 1'b1;
        return n;
    endfunction

    lpmr_ram #(
        .WIDTH (lpmr_pkg::DATA_W),
        .DEPTH (RING_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // space test against committed data only
    always_comb
    begin
        used = {1'b0, cwp_reg} - {1'b0, rp_reg};
        if (cwp_reg < rp_reg)
            used = used + (PW+1)'(RING_BYTES);
        free_bytes = (PW+1)'(RING_BYTES) - used;
        rsv_eff    = (reserve == '0) ? SW'(1) : SW'(reserve);
        need       = SW'(HEADER_BYTES) + SW'(len_reg) + rsv_eff;
        no_room    = (need > SW'(free_bytes)) || (total_reg >= lpmr_pkg::COUNT_MAX);
    end

    // popped header length, zero read as one
    always_comb
    begin
        plen = {len_hi_reg, len_lo_reg};
        if (plen == '0)
            plen = lpmr_pkg::LEN_W'(1);
    end

    assign ram_we    = (state_reg == lpmr_pkg::S_PUSH_HDR) ||
                       (state_reg == lpmr_pkg::S_PUSH_BODY);
    assign ram_addr  = ram_we ? pwp_reg : rp_reg;
    assign ram_wdata = (state_reg == lpmr_pkg::S_PUSH_HDR)
                       ? lpmr_pkg::hdr_byte(len_reg, 32'(hcnt_reg)) : data_reg;

    assign busy      = (state_reg != lpmr_pkg::S_IDLE);
    assign res_valid = (state_reg == lpmr_pkg::S_RESULT);
    assign res       = '{status: rstat_reg, out_byte: rbyte_reg, out_last: rlast_reg,
                         queued: total_reg};

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        data_next      = data_reg;
        len_next       = len_reg;
        rp_next        = rp_reg;
        cwp_next       = cwp_reg;
        pwp_next       = pwp_reg;
        total_next     = total_reg;
        push_left_next = push_left_reg;
        drop_next      = drop_reg;
        pop_left_next  = pop_left_reg;
        hcnt_next      = hcnt_reg;
        opened_next    = opened_reg;
        rstat_next     = rstat_reg;
        rbyte_next     = rbyte_reg;
        rlast_next     = rlast_reg;
        pop_left_dec   = (opened_reg ? plen : pop_left_reg) - 1'b1;

        case (state_reg)
            lpmr_pkg::S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = item_mode;
                    data_next  = item_data;
                    len_next   = item_len;
                    state_next = lpmr_pkg::S_DECIDE;
                end
            end

            lpmr_pkg::S_DECIDE:
            begin
                rbyte_next = '0;
                rlast_next = 1'b0;
                rstat_next = lpmr_pkg::ST_OK;
                if (!mode_reg)
                begin
                    if (push_left_reg == '0)
                    begin
                        if (len_reg == '0)
                        begin
                            rstat_next = lpmr_pkg::ST_ZERO;
                            state_next = lpmr_pkg::S_RESULT;
                        end
                        else if (no_room)
                        begin
                            push_left_next = len_reg - 1'b1;
                            drop_next      = (len_reg != lpmr_pkg::LEN_W'(1));
                            rstat_next     = lpmr_pkg::ST_DROP;
                            state_next     = lpmr_pkg::S_RESULT;
                        end
                        else
                        begin
                            drop_next      = 1'b0;
                            push_left_next = len_reg;
                            pwp_next       = cwp_reg;
                            hcnt_next      = '0;
                            state_next     = lpmr_pkg::S_PUSH_HDR;
                        end
                    end
                    else if (drop_reg)
                    begin
                        push_left_next = push_left_reg - 1'b1;
                        drop_next      = (push_left_reg != lpmr_pkg::LEN_W'(1));
                        rstat_next     = lpmr_pkg::ST_DROP;
                        state_next     = lpmr_pkg::S_RESULT;
                    end
                    else
                    begin
                        state_next = lpmr_pkg::S_PUSH_BODY;
                    end
                end
                else
                begin
                    if (pop_left_reg == '0)
                    begin
                        if (rp_reg == cwp_reg)
                        begin
                            rstat_next = lpmr_pkg::ST_EMPTY;
                            state_next = lpmr_pkg::S_RESULT;
                        end
                        else
                        begin
                            hcnt_next   = '0;
                            opened_next = 1'b1;
                            state_next  = lpmr_pkg::S_POP_HDR;
                        end
                    end
                    else
                    begin
                        opened_next = 1'b0;
                        state_next  = lpmr_pkg::S_POP_RD;
                    end
                end
            end

            lpmr_pkg::S_PUSH_HDR:
            begin
                pwp_next  = nxt(pwp_reg);
                hcnt_next = hcnt_reg + 1'b1;
                if (hcnt_reg == HDR_LAST)
                    state_next = lpmr_pkg::S_PUSH_BODY;
            end

            lpmr_pkg::S_PUSH_BODY:
            begin
                pwp_next       = nxt(pwp_reg);
                push_left_next = push_left_reg - 1'b1;
                if (push_left_reg == lpmr_pkg::LEN_W'(1))
                begin
                    // last byte: message becomes visible to pops
                    cwp_next   = nxt(pwp_reg);
                    total_next = total_reg + 1'b1;
                end
                state_next = lpmr_pkg::S_RESULT;
            end

            lpmr_pkg::S_POP_HDR:
            begin
                rp_next   = nxt(rp_reg);
                hcnt_next = hcnt_reg + 1'b1;
                if (hcnt_reg == HDR_LAST)
                    state_next = lpmr_pkg::S_POP_RD;
            end

            lpmr_pkg::S_POP_RD:
            begin
                rp_next    = nxt(rp_reg);
                state_next = lpmr_pkg::S_POP_WAIT;
            end

            lpmr_pkg::S_POP_WAIT:
            begin
                if (opened_reg && (total_reg != '0))
                    total_next = total_reg - 1'b1;
                pop_left_next = pop_left_dec;
                rbyte_next    = ram_rdata;
                rlast_next    = (pop_left_dec == '0);
                state_next    = lpmr_pkg::S_RESULT;
            end

            lpmr_pkg::S_RESULT:
            begin
                if (res_ready)
                    state_next = lpmr_pkg::S_IDLE;
            end

            default:
            begin
                state_next = lpmr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpmr_pkg::S_IDLE;
            rp_reg        <= '0;
            cwp_reg       <= '0;
            pwp_reg       <= '0;
            total_reg     <= '0;
            push_left_reg <= '0;
            drop_reg      <= 1'b0;
            pop_left_reg  <= '0;
            cap_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            cwp_reg       <= cwp_next;
            pwp_reg       <= pwp_next;
            total_reg     <= total_next;
            push_left_reg <= push_left_next;
            drop_reg      <= drop_next;
            pop_left_reg  <= pop_left_next;
            cap_valid_reg <= (state_reg == lpmr_pkg::S_POP_HDR);
        end
    end

    // payload and header capture, no reset
    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        data_reg    <= data_next;
        len_reg     <= len_next;
        hcnt_reg    <= hcnt_next;
        opened_reg  <= opened_next;
        rstat_reg   <= rstat_next;
        rbyte_reg   <= rbyte_next;
        rlast_reg   <= rlast_next;
        cap_idx_reg <= hcnt_reg;
        if (cap_valid_reg && (cap_idx_reg == HW'(0)))
            len_lo_reg <= ram_rdata;
        if (cap_valid_reg && (cap_idx_reg == HW'(1)))
            len_hi_reg <= ram_rdata[lpmr_pkg::LEN_HI_W-1:0];
    end

    a_write_only_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (mode_reg == 1'b0))
        else $error("ring written during a pop");

    a_drop_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg |-> (push_left_reg != '0))
        else $error("dropping with no bytes left");

    a_empty_means_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (rstat_reg == lpmr_pkg::ST_EMPTY)) |->
            ((rp_reg == cwp_reg) && (pop_left_reg == '0)))
        else $error("empty reported with data held");

    a_last_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && rlast_reg) |-> (rstat_reg == lpmr_pkg::ST_OK))
        else $error("last flag on a non-ok result");

endmodule

`default_nettype wire
